@@ hdl/cted_pkg.sv @@
`timescale 1ns / 1ps

package cted_pkg;

   // Digit and field geometry
   localparam int unsigned NUM_DIGITS   = 6;
   localparam int unsigned DIGIT_W      = 4;
   localparam int unsigned CURSOR_W     = 3;
   localparam int unsigned KIND_W       = 3;
   localparam int unsigned HOURS_W      = 6;
   localparam int unsigned MINUTES_W    = 7;
   localparam int unsigned SECONDS_W    = 7;
   localparam int unsigned PERIOD_W     = 10;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   // Item kinds; codes above KIND_LOAD behave as a tick
   localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UP     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd4;

   // Register map (byte addresses)
   localparam logic [CSR_ADDR_W-1:0] ADDR_BLINK_PERIOD = 3'd0;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET      = 10'd640;

   localparam logic [DIGIT_W-1:0]  GLYPH_BLANK = 4'd10;
   localparam logic [DIGIT_W-1:0]  GLYPH_MAX   = 4'd11;
   localparam logic [CURSOR_W-1:0] CURSOR_FIRST = 3'd1;
   localparam logic [CURSOR_W-1:0] CURSOR_LAST  = 3'd6;

   // Upper limit of each digit: hours tens, hours units, ..., seconds units
   localparam logic [DIGIT_W-1:0] DIGIT_LIMIT [NUM_DIGITS] = '{
      4'd2, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9
   };

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type digits_type [NUM_DIGITS];

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [HOURS_W-1:0]   load_hours_bcd;
      logic [MINUTES_W-1:0] load_minutes_bcd;
      logic [SECONDS_W-1:0] load_seconds_bcd;
   } req_type;

   typedef struct packed {
      logic [DIGIT_W-1:0]   shown_a;
      logic [DIGIT_W-1:0]   shown_b;
      logic [DIGIT_W-1:0]   shown_c;
      logic [DIGIT_W-1:0]   shown_d;
      logic [CURSOR_W-1:0]  cursor_position;
      logic                 value_mode;
      logic                 commit_valid;
      logic [HOURS_W-1:0]   commit_hours_bcd;
      logic [MINUTES_W-1:0] commit_minutes_bcd;
      logic [SECONDS_W-1:0] commit_seconds_bcd;
   } rsp_type;

   // Digit value to glyph code; out-of-range values show blank
   function automatic logic [DIGIT_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      return (d > GLYPH_MAX) ? GLYPH_BLANK : d;
   endfunction

endpackage

@@ hdl/cted_req_if.sv @@
`timescale 1ns / 1ps

interface cted_req_if;
   import cted_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [HOURS_W-1:0]   load_hours_bcd;
   logic [MINUTES_W-1:0] load_minutes_bcd;
   logic [SECONDS_W-1:0] load_seconds_bcd;

   modport source (output valid, kind, load_hours_bcd, load_minutes_bcd,
                   load_seconds_bcd, input ready);
   modport sink   (input valid, kind, load_hours_bcd, load_minutes_bcd,
                   load_seconds_bcd, output ready);
endinterface

@@ hdl/cted_rsp_if.sv @@
`timescale 1ns / 1ps

interface cted_rsp_if;
   import cted_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DIGIT_W-1:0]   shown_a;
   logic [DIGIT_W-1:0]   shown_b;
   logic [DIGIT_W-1:0]   shown_c;
   logic [DIGIT_W-1:0]   shown_d;
   logic [CURSOR_W-1:0]  cursor_position;
   logic                 value_mode;
   logic                 commit_valid;
   logic [HOURS_W-1:0]   commit_hours_bcd;
   logic [MINUTES_W-1:0] commit_minutes_bcd;
   logic [SECONDS_W-1:0] commit_seconds_bcd;

   modport source (output valid, shown_a, shown_b, shown_c, shown_d, cursor_position,
                   value_mode, commit_valid, commit_hours_bcd, commit_minutes_bcd,
                   commit_seconds_bcd, input ready);
   modport sink   (input valid, shown_a, shown_b, shown_c, shown_d, cursor_position,
                   value_mode, commit_valid, commit_hours_bcd, commit_minutes_bcd,
                   commit_seconds_bcd, output ready);
endinterface

@@ hdl/clock_time_set_editor_core.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Handshake      | Content
// req      | in        | valid / ready  | kind and BCD load time
// rsp      | out       | valid / ready  | four glyphs, cursor, mode, commit time
// csr      | in        | APB write/read | blink_period at byte address 0
//
// One transaction per cycle sustained while rsp.ready is high; a result passes from the input
// register through the edit/render logic into the output register, which drives rsp.
// Reset is synchronous and active high; it clears digits, mode and blink state, puts the
// cursor on digit 1 and loads the blink period with 640. req.ready drops only while both
// the input register and the output register hold transactions and rsp.ready is low.

module clock_time_set_editor_core (
   input  logic                            clock,
   input  logic                            reset,
   cted_req_if.sink                        req,
   cted_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cted_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cted_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cted_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import cted_pkg::*;

   localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

   // Pipeline control
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    out_free;
   logic    req_fire;
   logic    s2_fire;

   // Editor state
   digits_type           digits_ff;
   digits_type           digits_in;
   logic [CURSOR_W-1:0]  cursor_ff;
   logic [CURSOR_W-1:0]  cursor_in;
   logic                 mode_ff;
   logic                 mode_in;
   logic [PERIOD_W-1:0]  blink_count_ff;
   logic [PERIOD_W-1:0]  blink_count_in;
   logic                 blink_phase_ff;
   logic                 blink_phase_in;
   logic [PERIOD_W-1:0]  period_ff;
   rsp_type              out_data_in;

   assign out_free = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || out_free;
   assign req_fire = req.valid && req.ready;
   assign s2_fire = in_valid_ff && out_free;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_BLINK_PERIOD)
                       ? {{(CSR_DATA_W-PERIOD_W){1'b0}}, period_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == ADDR_BLINK_PERIOD) begin
         period_ff <= csr_pwdata[PERIOD_W-1:0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff.kind             <= req.kind;
         in_data_ff.load_hours_bcd   <= req.load_hours_bcd;
         in_data_ff.load_minutes_bcd <= req.load_minutes_bcd;
         in_data_ff.load_seconds_bcd <= req.load_seconds_bcd;
      end
   end

   // Edit, blink and render for the transaction in the input register
   always_comb begin
      logic [IDX_W-1:0]    k_old;
      logic [IDX_W-1:0]    k_new;
      logic [DIGIT_W:0]    up_val;
      logic [PERIOD_W:0]   cnt_inc;
      logic [DIGIT_W-1:0]  g [4];
      logic                commit;

      digits_in      = digits_ff;
      cursor_in      = cursor_ff;
      mode_in        = mode_ff;
      blink_count_in = blink_count_ff;
      blink_phase_in = blink_phase_ff;
      commit         = 1'b0;
      up_val         = '0;
      cnt_inc        = {1'b0, blink_count_ff} + {{PERIOD_W{1'b0}}, 1'b1};

      // selected digit index, clamped to the valid range
      if (cursor_ff < CURSOR_FIRST) begin
         k_old = '0;
      end else if (cursor_ff > CURSOR_LAST) begin
         k_old = IDX_W'(NUM_DIGITS - 1);
      end else begin
         k_old = IDX_W'(cursor_ff - CURSOR_FIRST);
      end

      if (in_data_ff.kind == KIND_LOAD) begin
         digits_in[0] = {2'b00, in_data_ff.load_hours_bcd[5:4]};
         digits_in[1] = in_data_ff.load_hours_bcd[3:0];
         digits_in[2] = {1'b0, in_data_ff.load_minutes_bcd[6:4]};
         digits_in[3] = in_data_ff.load_minutes_bcd[3:0];
         digits_in[4] = {1'b0, in_data_ff.load_seconds_bcd[6:4]};
         digits_in[5] = in_data_ff.load_seconds_bcd[3:0];
         cursor_in    = CURSOR_FIRST;
      end else begin
         case (in_data_ff.kind)
            KIND_BUTTON: begin
               commit  = mode_ff;
               mode_in = !mode_ff;
            end
            KIND_UP: begin
               if (mode_ff) begin
                  up_val = {1'b0, digits_ff[k_old]} + {{DIGIT_W{1'b0}}, 1'b1};
                  if (up_val > {1'b0, DIGIT_LIMIT[k_old]}) begin
                     digits_in[k_old] = DIGIT_LIMIT[k_old];
                  end else begin
                     digits_in[k_old] = up_val[DIGIT_W-1:0];
                  end
                  // hours stay at 23 or below
                  if (digits_in[0] == 4'd2 && digits_in[1] > 4'd3) begin
                     digits_in[1] = 4'd3;
                  end
               end else if (cursor_ff >= CURSOR_LAST) begin
                  cursor_in = CURSOR_LAST;
               end else begin
                  cursor_in = CURSOR_W'(k_old) + 3'd2;
               end
            end
            KIND_DOWN: begin
               if (mode_ff) begin
                  if (digits_ff[k_old] != '0) begin
                     digits_in[k_old] = digits_ff[k_old] - 4'd1;
                  end
               end else if (k_old == '0) begin
                  cursor_in = CURSOR_FIRST;
               end else begin
                  cursor_in = CURSOR_W'(k_old);
               end
            end
            default: begin
            end
         endcase

         // blink counter advance
         if (cnt_inc >= {1'b0, period_ff}) begin
            blink_phase_in = !blink_phase_ff;
            blink_count_in = '0;
         end else begin
            blink_count_in = cnt_inc[PERIOD_W-1:0];
         end
      end

      // render from the updated state
      if (cursor_in < CURSOR_FIRST) begin
         k_new = '0;
      end else if (cursor_in > CURSOR_LAST) begin
         k_new = IDX_W'(NUM_DIGITS - 1);
      end else begin
         k_new = IDX_W'(cursor_in - CURSOR_FIRST);
      end

      if (k_new < IDX_W'(4)) begin
         for (int i = 0; i < 4; i++) begin
            g[i] = glyph(digits_in[i]);
         end
         if (!blink_phase_in) begin
            g[k_new[1:0]] = GLYPH_BLANK;
         end
      end else begin
         g[0] = GLYPH_BLANK;
         g[1] = glyph(digits_in[4]);
         g[2] = glyph(digits_in[5]);
         g[3] = GLYPH_BLANK;
         if (!blink_phase_in) begin
            if (k_new == IDX_W'(4)) begin
               g[1] = GLYPH_BLANK;
            end else begin
               g[2] = GLYPH_BLANK;
            end
         end
      end

      out_data_in.shown_a         = g[0];
      out_data_in.shown_b         = g[1];
      out_data_in.shown_c         = g[2];
      out_data_in.shown_d         = g[3];
      out_data_in.cursor_position = cursor_in;
      out_data_in.value_mode      = mode_in;
      out_data_in.commit_valid    = commit;
      out_data_in.commit_hours_bcd   = commit ? {digits_ff[0][1:0], digits_ff[1]} : '0;
      out_data_in.commit_minutes_bcd = commit ? {digits_ff[2][2:0], digits_ff[3]} : '0;
      out_data_in.commit_seconds_bcd = commit ? {digits_ff[4][2:0], digits_ff[5]} : '0;
   end

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_ff[i] <= '0;
         end
         cursor_ff      <= CURSOR_FIRST;
         mode_ff        <= 1'b0;
         blink_count_ff <= '0;
         blink_phase_ff <= 1'b0;
      end else if (s2_fire) begin
         digits_ff      <= digits_in;
         cursor_ff      <= cursor_in;
         mode_ff        <= mode_in;
         blink_count_ff <= blink_count_in;
         blink_phase_ff <= blink_phase_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.shown_a            = out_data_ff.shown_a;
   assign rsp.shown_b            = out_data_ff.shown_b;
   assign rsp.shown_c            = out_data_ff.shown_c;
   assign rsp.shown_d            = out_data_ff.shown_d;
   assign rsp.cursor_position    = out_data_ff.cursor_position;
   assign rsp.value_mode         = out_data_ff.value_mode;
   assign rsp.commit_valid       = out_data_ff.commit_valid;
   assign rsp.commit_hours_bcd   = out_data_ff.commit_hours_bcd;
   assign rsp.commit_minutes_bcd = out_data_ff.commit_minutes_bcd;
   assign rsp.commit_seconds_bcd = out_data_ff.commit_seconds_bcd;

endmodule
